// ===== src/ctc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctc_pkg
// Shared types and constants of the cruise throttle controller.
// ----------------------------------------------------------------------------
package ctc_pkg;

    // config register indexes
    localparam logic [2:0] CFG_TARGET_SPEED = 3'd0;
    localparam logic [2:0] CFG_MIN_GAP      = 3'd1;
    localparam logic [2:0] CFG_GAIN_P       = 3'd2;
    localparam logic [2:0] CFG_GAIN_I       = 3'd3;
    localparam logic [2:0] CFG_GAIN_D       = 3'd4;
    localparam logic [2:0] CFG_HOLD_TICKS   = 3'd5;

    // config reset values
    localparam logic [16:0]        RST_TARGET_SPEED = 17'd12800;
    localparam logic [15:0]        RST_MIN_GAP      = 16'd1920;
    localparam logic signed [31:0] RST_GAIN_P       = 32'sd3355443;
    localparam logic signed [31:0] RST_GAIN_I       = -32'sd168;
    localparam logic signed [31:0] RST_GAIN_D       = -32'sd335544;
    localparam logic [15:0]        RST_HOLD_TICKS   = 16'd180;

    // throttle codes, Q2.14
    localparam logic signed [15:0] THR_FULL       = 16'sd16384;
    localparam logic signed [15:0] THR_ZERO       = 16'sd0;
    localparam logic signed [15:0] THR_HALF_BRAKE = -16'sd8192;
    localparam logic signed [15:0] THR_FULL_BRAKE = -16'sd16384;

    // speed thresholds, km/h * 256
    localparam logic signed [17:0] SPD_STOP   = 18'sd256;
    localparam logic signed [17:0] SPD_NEAR   = 18'sd10240;
    localparam logic signed [17:0] SPD_FAR    = 18'sd11520;
    localparam logic [17:0]        SPD_PID    = 18'd5120;
    localparam logic [17:0]        SPD_ABS_STOP = 18'd256;

    // gap margins, m * 64
    localparam logic [16:0] GAP_MARGIN_NEAR = 17'd320;
    localparam logic [16:0] GAP_MARGIN_FAR  = 17'd640;

    // output buffer
    localparam int CTC_FIFO_DEPTH = 8;
    localparam int CTC_PTR_W      = $clog2(CTC_FIFO_DEPTH);

    typedef struct packed {
        logic               stop_done;
        logic               brake_hold;
        logic signed [15:0] throttle;
    } t_result;

    typedef struct packed {
        logic               valid;
        logic               use_pid;
        logic signed [15:0] fixed_thr;
        logic               brake_hold;
        logic               stop_done;
        logic signed [18:0] err;
        logic signed [19:0] diff;
        logic signed [47:0] sum;
    } t_pid_req;

endpackage

// ===== src/cruise_throttle_controller_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cruise_throttle_controller_unit
// Adaptive cruise throttle: red-light hold, gap braking and a PID speed loop,
// one throttle word per sensor word.
// ----------------------------------------------------------------------------
//  channel   dir  width  contents
//  s_axis    in   40     speed, car flag, gap, red light, stop line
//  m_axis    out  24     throttle, brake hold, stop done
//  cfg       in   32     six control registers, write only
//
//  One word per cycle sustained while s_axis_tready is high.
//  The rule decision and all state update in one stage, so a word may follow
//  every cycle; products and sums go through three more pipeline stages.
//  Up to eight words are in flight; s_axis_tready drops once eight are
//  accepted and not yet taken, so a stalled m_axis side never loses a word.
//  Synchronous active-low reset clears state and restores register defaults.
// ----------------------------------------------------------------------------
module cruise_throttle_controller_unit
    import ctc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [17:0] ego_speed, [18] car_ahead, [34:19] gap_distance, [35] red_light,
    // [36] stop_line, [39:37] zero
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] throttle, [16] brake_hold, [17] stop_done, [23:18] zero
    output logic [23:0] m_axis_tdata,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_wr_data
);

    logic [16:0]        r_target_speed;
    logic [15:0]        r_min_gap;
    logic signed [31:0] r_gain_p;
    logic signed [31:0] r_gain_i;
    logic signed [31:0] r_gain_d;
    logic [15:0]        r_hold_ticks;

    logic signed [18:0] r_error_prev;
    logic signed [47:0] r_error_sum;
    logic [15:0]        r_hold_count;
    logic               r_stopped;

    logic signed [18:0] n_error_prev;
    logic signed [47:0] n_error_sum;
    logic [15:0]        n_hold_count;
    logic               n_stopped;

    logic               r_in_valid;
    logic signed [17:0] r_speed;
    logic               r_car;
    logic [15:0]        r_gap;
    logic               r_red;
    logic               r_line;

    logic [CTC_PTR_W:0] r_count;
    logic               in_acc;
    logic               out_acc;

    logic [17:0]        abs_speed;
    logic               close_car;
    logic [15:0]        hold_load;
    logic signed [48:0] sum_wide;
    logic signed [47:0] sum_sat;
    logic signed [18:0] err;
    logic signed [19:0] diff;

    t_pid_req           n_req;
    t_pid_req           r_req;
    logic               pid_valid;
    t_result            pid_result;
    t_result            out_result;

    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_acc       = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (r_count < (CTC_PTR_W+1)'(CTC_FIFO_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_speed <= RST_TARGET_SPEED;
            r_min_gap      <= RST_MIN_GAP;
            r_gain_p       <= RST_GAIN_P;
            r_gain_i       <= RST_GAIN_I;
            r_gain_d       <= RST_GAIN_D;
            r_hold_ticks   <= RST_HOLD_TICKS;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                CFG_TARGET_SPEED: r_target_speed <= i_cfg_wr_data[16:0];
                CFG_MIN_GAP:      r_min_gap      <= i_cfg_wr_data[15:0];
                CFG_GAIN_P:       r_gain_p       <= $signed(i_cfg_wr_data);
                CFG_GAIN_I:       r_gain_i       <= $signed(i_cfg_wr_data);
                CFG_GAIN_D:       r_gain_d       <= $signed(i_cfg_wr_data);
                CFG_HOLD_TICKS:   r_hold_ticks   <= i_cfg_wr_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= r_count + (CTC_PTR_W+1)'(in_acc) - (CTC_PTR_W+1)'(out_acc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_speed <= $signed(s_axis_tdata[17:0]);
            r_car   <= s_axis_tdata[18];
            r_gap   <= s_axis_tdata[34:19];
            r_red   <= s_axis_tdata[35];
            r_line  <= s_axis_tdata[36];
        end
    end

    assign abs_speed = r_speed[17] ? (~r_speed + 18'd1) : r_speed;
    assign close_car = r_car &&
        (((17'(r_gap) < 17'(r_min_gap) + GAP_MARGIN_NEAR) && (r_speed > SPD_NEAR)) ||
         ((17'(r_gap) < 17'(r_min_gap) + GAP_MARGIN_FAR) && (r_speed > SPD_FAR)));
    assign hold_load = (r_hold_ticks == 16'd0) ? 16'd0 : (r_hold_ticks - 16'd1);

    assign err      = $signed({2'b00, r_target_speed}) - 19'(r_speed);
    assign diff     = 20'(r_error_prev) - 20'(err);
    assign sum_wide = 49'(r_error_sum) + 49'(r_error_prev);

    always_comb begin
        if (sum_wide[48] != sum_wide[47]) begin
            sum_sat = sum_wide[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end else begin
            sum_sat = sum_wide[47:0];
        end
    end

    // rule decision and state update, one word per cycle
    always_comb begin
        n_error_prev    = r_error_prev;
        n_error_sum     = r_error_sum;
        n_hold_count    = r_hold_count;
        n_stopped       = r_stopped;
        n_req.valid      = r_in_valid;
        n_req.use_pid    = 1'b0;
        n_req.fixed_thr  = THR_FULL;
        n_req.brake_hold = 1'b0;
        n_req.err        = err;
        n_req.diff       = diff;
        n_req.sum        = sum_sat;
        if (r_hold_count != 16'd0) begin
            n_req.fixed_thr  = THR_FULL_BRAKE;
            n_req.brake_hold = 1'b1;
            n_hold_count     = r_hold_count - 16'd1;
            if (r_hold_count == 16'd1) begin
                n_stopped = 1'b1;
            end
        end else if (r_red && r_line && !r_stopped) begin
            n_req.fixed_thr = THR_HALF_BRAKE;
            if (r_speed < SPD_STOP) begin
                n_req.fixed_thr  = THR_FULL_BRAKE;
                n_req.brake_hold = 1'b1;
                n_hold_count     = hold_load;
                if (hold_load == 16'd0) begin
                    n_stopped = 1'b1;
                end
            end
        end else if (close_car) begin
            n_req.fixed_thr = THR_HALF_BRAKE;
        end else if (r_car && (r_gap <= r_min_gap)) begin
            n_req.fixed_thr = (abs_speed < SPD_ABS_STOP) ? THR_ZERO : THR_HALF_BRAKE;
        end else if (abs_speed > SPD_PID) begin
            n_req.use_pid = 1'b1;
            n_error_sum   = sum_sat;
            n_error_prev  = err;
        end
        n_req.stop_done = n_stopped;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_error_prev <= '0;
            r_error_sum  <= '0;
            r_hold_count <= '0;
            r_stopped    <= 1'b0;
            r_req        <= '0;
        end else begin
            if (r_in_valid) begin
                r_error_prev <= n_error_prev;
                r_error_sum  <= n_error_sum;
                r_hold_count <= n_hold_count;
                r_stopped    <= n_stopped;
            end
            r_req <= n_req;
        end
    end

    ctc_pid u_pid (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (r_req),
        .i_gain_p (r_gain_p),
        .i_gain_i (r_gain_i),
        .i_gain_d (r_gain_d),
        .o_valid  (pid_valid),
        .o_result (pid_result)
    );

    ctc_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (pid_valid),
        .i_wr_data (pid_result),
        .i_rd_en   (m_axis_tready),
        .o_valid   (m_axis_tvalid),
        .o_rd_data (out_result)
    );

    assign m_axis_tdata = {6'd0, out_result.stop_done, out_result.brake_hold,
                           out_result.throttle};

endmodule

// ===== src/ctc_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctc_fifo
// Small result queue in flops between the datapath and the output port.
// ----------------------------------------------------------------------------
module ctc_fifo
    import ctc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_wr_en,
    input  t_result i_wr_data,
    input  logic    i_rd_en,
    output logic    o_valid,
    output t_result o_rd_data
);

    t_result              r_mem [CTC_FIFO_DEPTH];
    logic [CTC_PTR_W:0]   r_wr_ptr;
    logic [CTC_PTR_W:0]   r_rd_ptr;
    logic [CTC_PTR_W:0]   n_wr_ptr;
    logic [CTC_PTR_W:0]   n_rd_ptr;

    assign o_valid   = (r_wr_ptr != r_rd_ptr);
    assign o_rd_data = r_mem[r_rd_ptr[CTC_PTR_W-1:0]];
    assign n_wr_ptr  = r_wr_ptr + (CTC_PTR_W+1)'(1);
    assign n_rd_ptr  = r_rd_ptr + (CTC_PTR_W+1)'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (i_wr_en) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_rd_en && o_valid) begin
                r_rd_ptr <= n_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_wr_ptr[CTC_PTR_W-1:0]] <= i_wr_data;
        end
    end

endmodule

// ===== src/ctc_pid.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctc_pid
// PID product and sum pipeline: multiply, partial sum, final sum with
// scaling and saturation, then select the throttle word.
// ----------------------------------------------------------------------------
module ctc_pid
    import ctc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_pid_req           i_req,
    input  logic signed [31:0] i_gain_p,
    input  logic signed [31:0] i_gain_i,
    input  logic signed [31:0] i_gain_d,
    output logic               o_valid,
    output t_result            o_result
);

    logic signed [23:0] sum_hi;
    logic signed [24:0] sum_lo;
    logic signed [50:0] n_pe;
    logic signed [51:0] n_pd;
    logic signed [55:0] n_phi;
    logic signed [56:0] n_plo;

    logic               r2_valid;
    logic               r2_use_pid;
    logic signed [15:0] r2_fixed;
    logic               r2_hold;
    logic               r2_done;
    logic signed [50:0] r2_pe;
    logic signed [51:0] r2_pd;
    logic signed [55:0] r2_phi;
    logic signed [56:0] r2_plo;

    logic signed [58:0] n_sum_a;
    logic               r3_valid;
    logic               r3_use_pid;
    logic signed [15:0] r3_fixed;
    logic               r3_hold;
    logic               r3_done;
    logic signed [58:0] r3_sum_a;
    logic signed [55:0] r3_phi;

    logic signed [80:0] total;
    logic signed [62:0] scaled;
    logic signed [15:0] pid_thr;

    assign sum_hi = i_req.sum[47:24];
    assign sum_lo = $signed({1'b0, i_req.sum[23:0]});
    assign n_pe   = i_req.err * i_gain_p;
    assign n_pd   = i_req.diff * i_gain_d;
    assign n_phi  = sum_hi * i_gain_i;
    assign n_plo  = sum_lo * i_gain_i;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            r2_valid <= i_req.valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_use_pid <= i_req.use_pid;
        r2_fixed   <= i_req.fixed_thr;
        r2_hold    <= i_req.brake_hold;
        r2_done    <= i_req.stop_done;
        r2_pe      <= n_pe;
        r2_pd      <= n_pd;
        r2_phi     <= n_phi;
        r2_plo     <= n_plo;
        r3_use_pid <= r2_use_pid;
        r3_fixed   <= r2_fixed;
        r3_hold    <= r2_hold;
        r3_done    <= r2_done;
        r3_sum_a   <= n_sum_a;
        r3_phi     <= r2_phi;
    end

    assign n_sum_a = 59'(r2_pe) + 59'(r2_pd) + 59'(r2_plo);

    // sum * gain_i split as hi * 2^24 + lo; floor shift by 18
    assign total  = $signed({r3_phi, 24'd0}) + 81'(r3_sum_a);
    assign scaled = total[80:18];

    always_comb begin
        if (scaled > 63'(THR_FULL)) begin
            pid_thr = THR_FULL;
        end else if (scaled < 63'(THR_FULL_BRAKE)) begin
            pid_thr = THR_FULL_BRAKE;
        end else begin
            pid_thr = scaled[15:0];
        end
    end

    assign o_valid             = r3_valid;
    assign o_result.throttle   = r3_use_pid ? pid_thr : r3_fixed;
    assign o_result.brake_hold = r3_hold;
    assign o_result.stop_done  = r3_done;

endmodule
